// ===== src/cfa_pkg.sv =====
// Package for the class-confidence fusion block: field widths, sizes and
// the structs exchanged between the store, the divider and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cfa_pkg;

  localparam int NUM_CLASSES = 32;
  localparam int IDX_BITS    = 5;
  localparam int CONF_BITS   = 16;
  localparam int COUNT_BITS  = 16;

  localparam int PROD_BITS   = CONF_BITS + COUNT_BITS;
  localparam int NUM_BITS    = PROD_BITS + 1;
  localparam int WSUM_BITS   = COUNT_BITS + 1;
  localparam int STEP_BITS   = $clog2(CONF_BITS);

  localparam logic                  MODE_MERGE = 1'b0;
  localparam logic                  MODE_CLEAR = 1'b1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};

  typedef struct packed {
    logic                 clr;
    logic                 we;
    logic [IDX_BITS-1:0]  waddr;
    logic [CONF_BITS-1:0] wdata;
  } store_cmd_t;

  typedef struct packed {
    logic                 start;
    logic [NUM_BITS-1:0]  dividend;
    logic [WSUM_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [CONF_BITS-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== src/cfa_if.sv =====
// Valid/ready channel interfaces for the input and result transactions.
// Depends on cfa_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface cfa_in_if;
  logic                           valid;
  logic                           ready;
  logic                           mode;
  logic [cfa_pkg::IDX_BITS-1:0]   class_index;
  logic [cfa_pkg::CONF_BITS-1:0]  confidence;
  logic [cfa_pkg::COUNT_BITS-1:0] other_updates;
  logic                           last_element;

  modport source (
    output valid, mode, class_index, confidence, other_updates, last_element,
    input  ready
  );
  modport sink (
    input  valid, mode, class_index, confidence, other_updates, last_element,
    output ready
  );
endinterface

interface cfa_out_if;
  logic                           valid;
  logic                           ready;
  logic [cfa_pkg::IDX_BITS-1:0]   best_class;
  logic                           class_valid;
  logic [cfa_pkg::COUNT_BITS-1:0] total_updates;

  modport source (
    output valid, best_class, class_valid, total_updates,
    input  ready
  );
  modport sink (
    input  valid, best_class, class_valid, total_updates,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/cfa_div.sv =====
// Serial restoring divider: one quotient bit per cycle, dividend shifted in
// bit by bit. Depends on cfa_pkg; quotient must fit in CONF_BITS.
`timescale 1ns / 1ps
`default_nettype none

module cfa_div (
  input  wire                clk,
  input  wire                rst_n,
  input  cfa_pkg::div_req_t  req,
  output cfa_pkg::div_rsp_t  rsp
);
  import cfa_pkg::*;

  logic [WSUM_BITS-1:0] rem_r, rem_nxt;
  logic [CONF_BITS-1:0] lo_r, lo_nxt;
  logic [CONF_BITS-1:0] quo_r, quo_nxt;
  logic [WSUM_BITS-1:0] dvs_r;
  logic [STEP_BITS-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [WSUM_BITS:0]   trial;
  logic [WSUM_BITS:0]   diff;

  assign trial = {rem_r, lo_r[CONF_BITS-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      // upper dividend bits are below the divisor since the quotient fits
      rem_nxt  = req.dividend[NUM_BITS-1:CONF_BITS];
      lo_nxt   = req.dividend[CONF_BITS-1:0];
      quo_nxt  = '0;
      cnt_nxt  = STEP_BITS'(CONF_BITS - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      lo_nxt = {lo_r[CONF_BITS-2:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[WSUM_BITS-1:0];
        quo_nxt = {quo_r[CONF_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = trial[WSUM_BITS-1:0];
        quo_nxt = {quo_r[CONF_BITS-2:0], 1'b0};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    quo_r <= quo_nxt;
    if (req.start) begin
      dvs_r <= req.divisor;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire

// ===== src/cfa_store.sv =====
// Per-class confidence store: one write port, one read port, and a clear
// command that zeroes all entries together. Depends on cfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfa_store (
  input  wire                            clk,
  input  wire                            rst_n,
  input  cfa_pkg::store_cmd_t            cmd,
  input  wire [cfa_pkg::IDX_BITS-1:0]    raddr,
  output logic [cfa_pkg::CONF_BITS-1:0]  rdata
);
  import cfa_pkg::*;

  logic [CONF_BITS-1:0] scores_r [NUM_CLASSES];

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        scores_r[i] <= '0;
      end
    end else if (cmd.we) begin
      scores_r[cmd.waddr] <= cmd.wdata;
    end
  end

  assign rdata = scores_r[raddr];

endmodule

`default_nettype wire

// ===== src/class_confidence_fuse_argmax_unit.sv =====
// Fuses an incoming per-class confidence vector, one class per transaction,
// into the stored vector as a count-weighted mean, and reports the best
// class after the last element. A merge transaction goes through accept,
// product, sum, 16 steps of the serial restoring divider (one quotient bit
// per cycle, the unit that sets the rate), its done flag, and
// the store/argmax update.
// When both counts are zero the divider is skipped.
// A clear transaction is carried out as it is accepted. The result sits in an output
// register, so new transactions are taken while it waits; only the update
// cycle of a last element holds until an earlier result has been taken.
// Depends on cfa_pkg, cfa_if, cfa_div and cfa_store.
`timescale 1ns / 1ps
`default_nettype none

module class_confidence_fuse_argmax_unit (
  input wire        clk,
  input wire        rst_n,
  cfa_in_if.sink    in_ch,
  cfa_out_if.source out_ch
);
  import cfa_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_SUM  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [IDX_BITS-1:0]   idx_r;
  logic [CONF_BITS-1:0]  conf_r;
  logic [CONF_BITS-1:0]  old_r;
  logic [COUNT_BITS-1:0] m_r;
  logic                  last_r;
  logic [PROD_BITS-1:0]  prod_a_r, prod_b_r;
  logic [WSUM_BITS-1:0]  wsum_r;

  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [CONF_BITS-1:0]  max_r, max_nxt;
  logic [IDX_BITS-1:0]   best_r, best_nxt;
  logic                  any_r, any_nxt;

  logic                  ovalid_r, ovalid_nxt;
  logic [IDX_BITS-1:0]   obest_r, obest_nxt;
  logic                  oclass_r, oclass_nxt;
  logic [COUNT_BITS-1:0] ototal_r, ototal_nxt;

  store_cmd_t            st_cmd;
  logic [CONF_BITS-1:0]  st_rdata;
  div_req_t              dv_req;
  div_rsp_t              dv_rsp;

  logic                  accept;
  logic                  fin_go;
  logic [CONF_BITS-1:0]  fused;
  logic [COUNT_BITS-1:0] wsat;
  logic                  take;

  cfa_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (st_cmd),
    .raddr (in_ch.class_index),
    .rdata (st_rdata)
  );

  cfa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dv_req),
    .rsp   (dv_rsp)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  assign fused  = (wsum_r == '0) ? old_r : dv_rsp.quotient;
  assign wsat   = wsum_r[COUNT_BITS] ? COUNT_MAX : wsum_r[COUNT_BITS-1:0];
  assign fin_go = (state_r == ST_FIN) && (!last_r || !ovalid_r || out_ch.ready);
  assign take   = (fused != '0) &&
                  (!any_r || (fused > max_r) || ((fused == max_r) && (idx_r < best_r)));

  always_comb begin
    dv_req.start    = (state_r == ST_SUM) && (wsum_r != '0);
    dv_req.dividend = {1'b0, prod_a_r} + {1'b0, prod_b_r};
    dv_req.divisor  = wsum_r;

    st_cmd.clr   = accept && (in_ch.mode == MODE_CLEAR);
    st_cmd.we    = fin_go && (wsum_r != '0);
    st_cmd.waddr = idx_r;
    st_cmd.wdata = fused;
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    max_nxt    = max_r;
    best_nxt   = best_r;
    any_nxt    = any_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    obest_nxt  = obest_r;
    oclass_nxt = oclass_r;
    ototal_nxt = ototal_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_ch.mode == MODE_CLEAR) begin
            count_nxt = '0;
            max_nxt   = '0;
            best_nxt  = '0;
            any_nxt   = 1'b0;
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        state_nxt = (wsum_r == '0) ? ST_FIN : ST_DIV;
      end
      ST_DIV: begin
        if (dv_rsp.done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          state_nxt = ST_IDLE;
          if (take) begin
            max_nxt  = fused;
            best_nxt = idx_r;
          end
          if (fused != '0) begin
            any_nxt = 1'b1;
          end
          if (last_r) begin
            ovalid_nxt = 1'b1;
            oclass_nxt = any_nxt;
            obest_nxt  = any_nxt ? best_nxt : '0;
            ototal_nxt = wsat;
            count_nxt  = wsat;
            max_nxt    = '0;
            best_nxt   = '0;
            any_nxt    = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      max_r    <= '0;
      best_r   <= '0;
      any_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      max_r    <= max_nxt;
      best_r   <= best_nxt;
      any_r    <= any_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    obest_r  <= obest_nxt;
    oclass_r <= oclass_nxt;
    ototal_r <= ototal_nxt;
    if (accept) begin
      idx_r  <= in_ch.class_index;
      conf_r <= in_ch.confidence;
      old_r  <= st_rdata;
      m_r    <= in_ch.other_updates;
      last_r <= in_ch.last_element;
    end
    if (state_r == ST_MUL) begin
      prod_a_r <= count_r * old_r;
      prod_b_r <= m_r * conf_r;
      wsum_r   <= {1'b0, count_r} + {1'b0, m_r};
    end
  end

  assign out_ch.valid         = ovalid_r;
  assign out_ch.best_class    = obest_r;
  assign out_ch.class_valid   = oclass_r;
  assign out_ch.total_updates = ototal_r;

endmodule

`default_nettype wire
